[hw/rtl/tvss_pkg.sv]
package tvss_pkg;

    // Field widths of the view descriptor
    localparam int SIZE_W   = 31;
    localparam int STRIDE_W = 32;
    localparam int BASE_W   = 40;
    localparam int IDX_W    = 32;
    localparam int WIDE_W   = 64;

    // Quotient bits of the element-count divider, one pipeline stage each
    localparam int DIV_BITS = SIZE_W;

    // Default width of the index-like fields as read by the core
    localparam int INDEX_BITS_DEF = 32;

    // Packed bus widths
    localparam int S_TDATA_W = 200;
    localparam int M_TDATA_W = 192;
    localparam int M_TUSER_W = 2;

    // Request kinds
    typedef enum logic {
        CMD_SELECT = 1'b0,
        CMD_SLICE  = 1'b1
    } cmd_t;

    // Result status
    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_EMPTY_DIM = 2'd1,
        ERR_RANGE     = 2'd2,
        ERR_STEP      = 2'd3
    } err_code_t;

    // Decoded and clamped request
    typedef struct packed {
        logic                       is_slice;
        err_code_t                  err;
        logic [SIZE_W-1:0]          start;
        logic [SIZE_W-1:0]          stop;
        logic [SIZE_W-1:0]          step;
        logic signed [STRIDE_W-1:0] stride;
        logic [BASE_W-1:0]          base;
    } tvss_dec_t;

    // Products and span
    typedef struct packed {
        logic                     is_slice;
        err_code_t                err;
        logic [SIZE_W-1:0]        nidx;
        logic [SIZE_W-1:0]        span;
        logic                     nonempty;
        logic [SIZE_W-1:0]        divisor;
        logic signed [WIDE_W-1:0] prod_off;
        logic signed [WIDE_W-1:0] prod_str;
        logic [BASE_W-1:0]        base;
    } tvss_mul_t;

    // Finished fields carried alongside the divider
    typedef struct packed {
        logic [WIDE_W-1:0] offset;
        logic [WIDE_W-1:0] stride;
        logic [SIZE_W-1:0] nidx;
        err_code_t         err;
        logic              nonempty;
    } tvss_side_t;

    // One divider stage: partial remainder, dividend/quotient shift word, divisor
    typedef struct packed {
        logic [SIZE_W-1:0] rem;
        logic [SIZE_W-1:0] work;
        logic [SIZE_W-1:0] divisor;
        tvss_side_t        side;
    } tvss_div_t;

endpackage

[hw/rtl/tensor_view_select_slice_calc_core.sv]
// Channel  Dir  Handshake           Payload
// s_       in   s_tvalid s_tready   s_tdata: request fields, s_tuser: command
// m_       out  m_tvalid m_tready   m_tdata: view fields, m_tuser: error_code
//
// One transaction per cycle sustained while m_ is not stalled; each request passes through
// decode, multiply, 31 restoring-divider stages for the element count and the output register.
// Reset (aresetn low, synchronous) empties every stage; payload registers are not cleared.
// Each stage has its own valid bit and advances when it is empty or the stage after it
// moves, so a stall on m_ backs up stage by stage and bubbles are squeezed out.
module tensor_view_select_slice_calc_core
    import tvss_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // dim_len[30:0], elem_stride[62:31], base_offset[102:63], index_or_start[134:103],
    // stop_bound[166:135], step_size[198:167], zero [199]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // command[0]
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // view_offset[63:0], view_stride[127:64], view_size[158:128], norm_index[189:159],
    // zero [191:190]
    output logic [M_TDATA_W-1:0] m_tdata,
    // error_code[1:0]
    output logic [M_TUSER_W-1:0] m_tuser
);

    // Effective width of the index-like fields
    localparam int IW = (INDEX_BITS < IDX_W) ? INDEX_BITS : IDX_W;

    // Clamp a bound Python-style into [0, n]
    function automatic logic [SIZE_W-1:0] clamp_bound(input logic signed [IDX_W:0] b,
                                                      input logic [SIZE_W-1:0]     n);
        logic signed [IDX_W:0] nn;
        logic signed [IDX_W:0] sum;
        logic [SIZE_W-1:0]     r;
        nn  = {2'b00, n};
        sum = b + nn;
        if (b[IDX_W]) begin
            r = sum[IDX_W] ? '0 : sum[SIZE_W-1:0];
        end else if (b > nn) begin
            r = n;
        end else begin
            r = b[SIZE_W-1:0];
        end
        return r;
    endfunction

    // One restoring division step: returns {rem, work}
    function automatic logic [2*SIZE_W-1:0] div_step(input logic [SIZE_W-1:0] rem,
                                                     input logic [SIZE_W-1:0] work,
                                                     input logic [SIZE_W-1:0] d);
        logic [SIZE_W:0]   trial;
        logic [SIZE_W+1:0] diff;
        logic              q;
        logic [SIZE_W-1:0] rem_n;
        trial = {rem, work[SIZE_W-1]};
        diff  = {1'b0, trial} - {2'b00, d};
        q     = ~diff[SIZE_W+1];
        rem_n = q ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
        return {rem_n, work[SIZE_W-2:0], q};
    endfunction

    // Unpack the request
    logic [SIZE_W-1:0]          in_size;
    logic signed [STRIDE_W-1:0] in_stride;
    logic [BASE_W-1:0]          in_base;
    logic [IDX_W-1:0]           in_first_raw;
    logic [IDX_W-1:0]           in_stop_raw;
    logic [IDX_W-1:0]           in_step_raw;
    logic signed [IDX_W:0]      in_first;
    logic signed [IDX_W:0]      in_stop;
    logic signed [IDX_W:0]      in_step;

    assign in_size      = s_tdata[30:0];
    assign in_stride    = $signed(s_tdata[62:31]);
    assign in_base      = s_tdata[102:63];
    assign in_first_raw = s_tdata[134:103];
    assign in_stop_raw  = s_tdata[166:135];
    assign in_step_raw  = s_tdata[198:167];
    assign in_first     = (IDX_W+1)'($signed(in_first_raw[IW-1:0]));
    assign in_stop      = (IDX_W+1)'($signed(in_stop_raw[IW-1:0]));
    assign in_step      = (IDX_W+1)'($signed(in_step_raw[IW-1:0]));

    // Stage enables, from the output back to the input
    logic                dec_valid_reg;
    logic                mul_valid_reg;
    logic [DIV_BITS-1:0] div_valid_reg;
    logic                out_valid_reg;
    logic                out_en;
    logic [DIV_BITS-1:0] div_en;
    logic                mul_en;
    logic                dec_en;

    assign out_en = !out_valid_reg || m_tready;
    always_comb begin
        div_en[DIV_BITS-1] = !div_valid_reg[DIV_BITS-1] || out_en;
        for (int k = DIV_BITS - 2; k >= 0; k--) begin
            div_en[k] = !div_valid_reg[k] || div_en[k+1];
        end
    end
    assign mul_en   = !mul_valid_reg || div_en[0];
    assign dec_en   = !dec_valid_reg || mul_en;
    assign s_tready = dec_en;

    // Decode: wrap and clamp the bounds, classify errors
    tvss_dec_t dec_next;
    tvss_dec_t dec_reg;
    logic      sel_ok;
    logic signed [IDX_W:0] first_wrap;

    always_comb begin
        first_wrap = in_first + $signed({2'b00, in_size});
        sel_ok     = in_first[IDX_W] ? !first_wrap[IDX_W] : (in_first < $signed({2'b00, in_size}));
        dec_next.is_slice = (s_tuser == CMD_SLICE);
        dec_next.start    = clamp_bound(in_first, in_size);
        dec_next.stop     = clamp_bound(in_stop, in_size);
        dec_next.step     = in_step[SIZE_W-1:0];
        dec_next.stride   = in_stride;
        dec_next.base     = in_base;
        if (s_tuser == CMD_SLICE) begin
            dec_next.err = (in_step[IDX_W] || in_step == '0) ? ERR_STEP : ERR_NONE;
        end else if (in_size == '0) begin
            dec_next.err = ERR_EMPTY_DIM;
        end else begin
            dec_next.err = sel_ok ? ERR_NONE : ERR_RANGE;
        end
    end

    // Multiply: offset product, stride product and span
    tvss_mul_t mul_next;
    tvss_mul_t mul_reg;

    always_comb begin
        mul_next.is_slice = dec_reg.is_slice;
        mul_next.err      = dec_reg.err;
        mul_next.nidx     = dec_reg.start;
        mul_next.span     = dec_reg.stop + ~dec_reg.start;
        mul_next.nonempty = dec_reg.stop > dec_reg.start;
        mul_next.divisor  = dec_reg.step;
        mul_next.prod_off = $signed({1'b0, dec_reg.start}) * dec_reg.stride;
        mul_next.prod_str = dec_reg.stride * $signed({1'b0, dec_reg.step});
        mul_next.base     = dec_reg.base;
    end

    // Final offset and stride, zeroed on error; the stride is also zeroed for a select
    tvss_side_t side_next;
    logic       mul_ok;

    always_comb begin
        mul_ok             = (mul_reg.err == ERR_NONE);
        side_next.offset   = mul_ok ? WIDE_W'(mul_reg.prod_off + $signed({24'b0, mul_reg.base}))
                                    : '0;
        side_next.stride   = (mul_ok && mul_reg.is_slice) ? mul_reg.prod_str : '0;
        side_next.nidx     = mul_ok ? mul_reg.nidx : '0;
        side_next.err      = mul_reg.err;
        side_next.nonempty = mul_ok && mul_reg.is_slice && mul_reg.nonempty;
    end

    // Divider pipeline: one quotient bit per stage
    tvss_div_t div_reg  [DIV_BITS];
    tvss_div_t div_next [DIV_BITS];

    always_comb begin
        div_next[0].divisor                  = mul_reg.divisor;
        div_next[0].side                     = side_next;
        {div_next[0].rem, div_next[0].work}  = div_step('0, mul_reg.span, mul_reg.divisor);
        for (int k = 1; k < DIV_BITS; k++) begin
            div_next[k].divisor = div_reg[k-1].divisor;
            div_next[k].side    = div_reg[k-1].side;
            {div_next[k].rem, div_next[k].work} =
                div_step(div_reg[k-1].rem, div_reg[k-1].work, div_reg[k-1].divisor);
        end
    end

    // Output fields
    logic [M_TDATA_W-1:0] out_data_next;
    logic [M_TDATA_W-1:0] out_data_reg;
    err_code_t            out_err_next;
    err_code_t            out_err_reg;
    logic [SIZE_W-1:0]    count_next;
    tvss_side_t           last_side;

    always_comb begin
        last_side     = div_reg[DIV_BITS-1].side;
        count_next    = last_side.nonempty ? div_reg[DIV_BITS-1].work + 1'b1 : '0;
        out_data_next = {2'b00, last_side.nidx, count_next, last_side.stride, last_side.offset};
        out_err_next  = last_side.err;
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dec_valid_reg <= 1'b0;
            mul_valid_reg <= 1'b0;
            div_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (dec_en) begin
                dec_valid_reg <= s_tvalid;
            end
            if (mul_en) begin
                mul_valid_reg <= dec_valid_reg;
            end
            if (div_en[0]) begin
                div_valid_reg[0] <= mul_valid_reg;
            end
            for (int k = 1; k < DIV_BITS; k++) begin
                if (div_en[k]) begin
                    div_valid_reg[k] <= div_valid_reg[k-1];
                end
            end
            if (out_en) begin
                out_valid_reg <= div_valid_reg[DIV_BITS-1];
            end
        end
    end

    // Payload registers; hold while a stage is stalled
    always_ff @(posedge aclk) begin
        if (dec_en) begin
            dec_reg <= dec_next;
        end
        if (mul_en) begin
            mul_reg <= mul_next;
        end
        for (int k = 0; k < DIV_BITS; k++) begin
            if (div_en[k]) begin
                div_reg[k] <= div_next[k];
            end
        end
        if (out_en) begin
            out_data_reg <= out_data_next;
            out_err_reg  <= out_err_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_err_reg;

endmodule

[dv/tensor_view_select_slice_calc_checker.sv]
module tensor_view_select_slice_calc_checker
    import tvss_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    // dim_len, elem_stride, base_offset, index_or_start, stop_bound, step_size, zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // command
    input  logic                 s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    // view_offset, view_stride, view_size, norm_index, zero
    input  logic [M_TDATA_W-1:0] m_tdata,
    // error_code
    input  logic [M_TUSER_W-1:0] m_tuser,
    output int                   fail_count,
    output int                   pending_count,
    output int                   result_count
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [WIDE_W-1:0] offset;
        logic [WIDE_W-1:0] stride;
        logic [SIZE_W-1:0] size;
        logic [SIZE_W-1:0] nidx;
        err_code_t         err;
    } view_t;

    view_t view_q[$];
    int    fails   = 0;
    int    pending = 0;
    int    checked = 0;

    assign fail_count    = fails;
    assign pending_count = pending;
    assign result_count  = checked;

    // Sign-extend an index-like field from its low INDEX_BITS bits
    function automatic longint read_index(logic [IDX_W-1:0] f);
        int                      sh;
        logic signed [IDX_W-1:0] t;
        sh = (INDEX_BITS < IDX_W) ? IDX_W - INDEX_BITS : 0;
        t  = signed'(f << sh);
        t  = t >>> sh;
        return longint'(t);
    endfunction

    // Clamp a slice bound into [0, n], negative counting from the end
    function automatic longint clamp_to_dim(longint b, longint n);
        if (b < 0) begin
            return (b < -n) ? 0 : b + n;
        end
        return (b > n) ? n : b;
    endfunction

    // Compute the view that one descriptor should produce
    function automatic view_t predict_view(logic cmd, logic [SIZE_W-1:0] dim,
                                           logic [STRIDE_W-1:0] stride_f,
                                           logic [BASE_W-1:0] base_f,
                                           logic [IDX_W-1:0] first_f,
                                           logic [IDX_W-1:0] stop_f,
                                           logic [IDX_W-1:0] step_f);
        view_t  v;
        longint n, stride, base, first, stop, step, idx, s, e;
        v.offset = '0;
        v.stride = '0;
        v.size   = '0;
        v.nidx   = '0;
        v.err    = ERR_NONE;
        n        = longint'(dim);
        stride   = longint'(signed'(stride_f));
        base     = longint'(base_f);
        first    = read_index(first_f);
        stop     = read_index(stop_f);
        step     = read_index(step_f);
        if (cmd == CMD_SELECT) begin
            if (n <= 0) begin
                v.err = ERR_EMPTY_DIM;
            end else begin
                idx = first;
                if (idx < 0) idx = (idx < -n) ? -1 : idx + n;
                if (idx < 0 || idx >= n) begin
                    v.err = ERR_RANGE;
                end else begin
                    v.offset = base + idx * stride;
                    v.nidx   = SIZE_W'(idx);
                end
            end
        end else if (step <= 0) begin
            v.err = ERR_STEP;
        end else begin
            s = clamp_to_dim(first, n);
            e = clamp_to_dim(stop, n);
            if (e > s) v.size = SIZE_W'(1 + (e - s - 1) / step);
            v.offset = base + s * stride;
            v.stride = stride * step;
            v.nidx   = SIZE_W'(s);
        end
        return v;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("[%0t] result %0d: %s got %h want %h", $time, checked, what, got, want);
        fails++;
    endtask

    // Predict on each input transaction, compare on each output transaction
    always @(posedge aclk) begin
        view_t got;
        view_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                view_q.push_back(predict_view(s_tuser, s_tdata[30:0], s_tdata[62:31],
                                              s_tdata[102:63], s_tdata[134:103],
                                              s_tdata[166:135], s_tdata[198:167]));
            end
            if (m_tvalid && m_tready) begin
                got.offset = m_tdata[63:0];
                got.stride = m_tdata[127:64];
                got.size   = m_tdata[158:128];
                got.nidx   = m_tdata[189:159];
                got.err    = err_code_t'(m_tuser);
                if (view_q.size() == 0) begin
                    report_mismatch("unexpected result, view_offset", got.offset, '0);
                end else begin
                    want = view_q.pop_front();
                    if (got.offset !== want.offset)
                        report_mismatch("view_offset", got.offset, want.offset);
                    if (got.stride !== want.stride)
                        report_mismatch("view_stride", got.stride, want.stride);
                    if (got.size !== want.size)
                        report_mismatch("view_size", 64'(got.size), 64'(want.size));
                    if (got.nidx !== want.nidx)
                        report_mismatch("norm_index", 64'(got.nidx), 64'(want.nidx));
                    if (m_tuser !== want.err)
                        report_mismatch("error_code", 64'(m_tuser), 64'(want.err));
                    if (m_tdata[191:190] !== 2'b00)
                        report_mismatch("tdata pad", 64'(m_tdata[191:190]), '0);
                end
                checked++;
            end
            pending = view_q.size();
        end
    end

endmodule

[dv/tb_tensor_view_select_slice_calc_core.sv]
module tb_tensor_view_select_slice_calc_core
    import tvss_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [SIZE_W-1:0] DIM_MAX = 31'h7FFF_FFFF;
    localparam logic [IDX_W-1:0]  IDX_MAX = 32'h7FFF_FFFF;
    localparam logic [IDX_W-1:0]  IDX_MIN = 32'h8000_0000;
    localparam logic [BASE_W-1:0] BASE_MAX = 40'hFF_FFFF_FFFF;
    localparam int                RANDOM_ITEMS = 650;
    localparam int                QUIET_ITEMS  = 100;

    typedef struct {
        cmd_t                cmd;
        logic [SIZE_W-1:0]   dim;
        logic [STRIDE_W-1:0] stride;
        logic [BASE_W-1:0]   base;
        logic [IDX_W-1:0]    first;
        logic [IDX_W-1:0]    stop;
        logic [IDX_W-1:0]    step;
    } view_req_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    int fail_count;
    int pending_count;
    int result_count;
    int n_select = 0;
    int n_slice  = 0;
    int gap_pct  = 0;

    tensor_view_select_slice_calc_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    tensor_view_select_slice_calc_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .result_count  (result_count)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Stop a hung run
    initial begin
        #2_000_000;
        $display("tensor_view_select_slice_calc_core regression: fail");
        $finish;
    end

    // Stall the result channel in random bursts
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && gap_pct > 0 && $urandom_range(99, 0) < gap_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(17, 1)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // Present one descriptor, possibly after an idle burst, and hold until accepted
    task automatic send_view_req(input view_req_t r);
        if (gap_pct > 0 && $urandom_range(99, 0) < gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(17, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.cmd;
        s_tdata  <= {1'b0, r.step, r.stop, r.first, r.base, r.stride, r.dim};
        if (r.cmd == CMD_SELECT) n_select++;
        else n_slice++;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_fields(cmd_t cmd, logic [SIZE_W-1:0] dim, logic [STRIDE_W-1:0] stride,
                               logic [BASE_W-1:0] base, logic [IDX_W-1:0] first,
                               logic [IDX_W-1:0] stop, logic [IDX_W-1:0] step);
        view_req_t r;
        r.cmd    = cmd;
        r.dim    = dim;
        r.stride = stride;
        r.base   = base;
        r.first  = first;
        r.stop   = stop;
        r.step   = step;
        send_view_req(r);
    endtask

    // Bound near the dimension edges, either sign, a little past the ends
    function automatic logic [IDX_W-1:0] pick_bound(logic [SIZE_W-1:0] dim);
        longint unsigned mag;
        mag = $urandom;
        mag = mag % (longint'(dim) + 3);
        return $urandom_range(1, 0) ? IDX_W'(-longint'(mag)) : IDX_W'(mag);
    endfunction

    function automatic view_req_t make_view_req();
        view_req_t r;
        int        k;
        r.cmd = cmd_t'($urandom_range(1, 0));
        k = $urandom_range(99, 0);
        if (k < 8)       r.dim = '0;
        else if (k < 55) r.dim = SIZE_W'($urandom_range(24, 1));
        else if (k < 85) r.dim = SIZE_W'($urandom);
        else             r.dim = DIM_MAX;
        r.first = ($urandom_range(9, 0) < 8) ? pick_bound(r.dim) : IDX_W'($urandom);
        r.stop  = ($urandom_range(9, 0) < 8) ? pick_bound(r.dim) : IDX_W'($urandom);
        k = $urandom_range(99, 0);
        if (k < 70)      r.step = IDX_W'($urandom_range(8, 1));
        else if (k < 80) r.step = IDX_W'($urandom_range(DIM_MAX, 1));
        else if (k < 88) r.step = IDX_W'(-$urandom_range(3, 0));
        else             r.step = IDX_W'($urandom);
        k = $urandom_range(99, 0);
        r.stride = (k < 40) ? STRIDE_W'($urandom_range(16, 0) - 8) : STRIDE_W'($urandom);
        k = $urandom_range(99, 0);
        if (k < 10)      r.base = '0;
        else if (k < 20) r.base = BASE_MAX;
        else             r.base = BASE_W'({$urandom, $urandom});
        return r;
    endfunction

    // Reset, directed corners, random descriptors, drain, verdict
    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // select: empty dim, wrap, both range edges, extreme index and stride
        send_fields(CMD_SELECT, 31'd0, 32'd5, 40'd7, 32'd0, 32'd0, 32'd0);
        send_fields(CMD_SELECT, 31'd1, IDX_MAX, BASE_MAX, 32'd0, 32'd0, 32'd0);
        send_fields(CMD_SELECT, 31'd10, IDX_MIN, 40'd100, -32'sd1, 32'd0, 32'd0);
        send_fields(CMD_SELECT, 31'd10, 32'd3, 40'd0, 32'd9, 32'd0, 32'd0);
        send_fields(CMD_SELECT, 31'd10, 32'd3, 40'd0, 32'd10, 32'd0, 32'd0);
        send_fields(CMD_SELECT, 31'd10, 32'd3, 40'd0, -32'sd10, 32'd0, 32'd0);
        send_fields(CMD_SELECT, 31'd10, 32'd3, 40'd0, -32'sd11, 32'd0, 32'd0);
        send_fields(CMD_SELECT, DIM_MAX, 32'd1, 40'd0, IDX_MAX, 32'd0, 32'd0);
        send_fields(CMD_SELECT, DIM_MAX, IDX_MIN, BASE_MAX, 32'h7FFF_FFFE, 32'd0, 32'd0);
        send_fields(CMD_SELECT, DIM_MAX, 32'd1, 40'd0, IDX_MIN, 32'd0, 32'd0);
        send_fields(CMD_SELECT, DIM_MAX, IDX_MAX, 40'd1, 32'h8000_0001, 32'd0, 32'd0);
        send_fields(CMD_SELECT, 31'd1, 32'hFFFF_FFFF, 40'd0, -32'sd1, IDX_MIN, IDX_MIN);
        // slice: bad steps, empty dim, clamping, empty span, extreme products
        send_fields(CMD_SLICE, 31'd10, 32'd2, 40'd5, 32'd0, 32'd10, 32'd0);
        send_fields(CMD_SLICE, 31'd10, 32'd2, 40'd5, 32'd0, 32'd10, 32'hFFFF_FFFF);
        send_fields(CMD_SLICE, 31'd10, 32'd2, 40'd5, 32'd0, 32'd10, IDX_MIN);
        send_fields(CMD_SLICE, 31'd0, 32'd2, 40'd5, 32'd0, 32'd0, 32'd1);
        send_fields(CMD_SLICE, 31'd10, 32'd4, 40'd9, 32'd0, 32'd10, 32'd1);
        send_fields(CMD_SLICE, 31'd10, 32'd4, 40'd9, IDX_MIN, IDX_MAX, 32'd3);
        send_fields(CMD_SLICE, 31'd10, 32'd4, 40'd9, 32'd7, 32'd3, 32'd1);
        send_fields(CMD_SLICE, 31'd10, -32'sd4, 40'd9, -32'sd3, -32'sd1, 32'd1);
        send_fields(CMD_SLICE, DIM_MAX, IDX_MIN, BASE_MAX, 32'd0, IDX_MAX, IDX_MAX);
        send_fields(CMD_SLICE, DIM_MAX, IDX_MAX, BASE_MAX, 32'd1, IDX_MAX, 32'd2);
        send_fields(CMD_SLICE, 31'd10, 32'd1, 40'd0, 32'd20, 32'd30, 32'd1);
        send_fields(CMD_SLICE, 31'd5, IDX_MAX, 40'd0, 32'd0, 32'd5, IDX_MAX);

        // random descriptors; idle profile changes every 80, quiet at the end
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i >= RANDOM_ITEMS - QUIET_ITEMS) gap_pct = 0;
            else if (i % 80 == 0) begin
                case ($urandom_range(2, 0))
                    0: gap_pct = 0;
                    1: gap_pct = 8;
                    default: gap_pct = 30;
                endcase
            end
            send_view_req(make_view_req());
        end
        s_tvalid <= 1'b0;

        // drain the pipeline
        while (pending_count != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        $display("sent %0d select and %0d slice descriptors, %0d views checked",
                 n_select, n_slice, result_count);
        if (fail_count == 0) begin
            $display("tensor_view_select_slice_calc_core regression: pass");
        end else begin
            $display("tensor_view_select_slice_calc_core regression: fail");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/tvss_pkg.sv
hw/rtl/tensor_view_select_slice_calc_core.sv
dv/tensor_view_select_slice_calc_checker.sv
dv/tb_tensor_view_select_slice_calc_core.sv
